// ----- rtl/tle_pkg.sv -----
// ----------------------------------------------------------------------------
// tle_pkg
// Shared types and constants for the terminal line editor.
// ----------------------------------------------------------------------------
package tle_pkg;

    localparam logic [7:0] C_BELL  = 8'd7;
    localparam logic [7:0] C_BS    = 8'd8;
    localparam logic [7:0] C_TAB   = 8'd9;
    localparam logic [7:0] C_LF    = 8'd10;
    localparam logic [7:0] C_CR    = 8'd13;
    localparam logic [7:0] C_ESC   = 8'd27;
    localparam logic [7:0] C_SPACE = 8'd32;
    localparam logic [7:0] C_LBRK  = 8'd91;
    localparam logic [7:0] C_DEL   = 8'd127;
    localparam logic [7:0] C_KEY_A = 8'd65;
    localparam logic [7:0] C_KEY_B = 8'd66;
    localparam logic [7:0] C_KEY_C = 8'd67;
    localparam logic [7:0] C_KEY_D = 8'd68;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       chunk_end;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_kind;
        logic       run_last;
    } t_out;

    typedef enum logic [2:0] {
        OP_INSERT,
        OP_DELETE,
        OP_BELL,
        OP_ENTER,
        OP_RIGHT,
        OP_LEFT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] ch;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_SHIFT,
        S_INS_ECHO,
        S_INS_LEFT,
        S_DEL_BS,
        S_DEL_SHIFT,
        S_DEL_SPACE,
        S_DEL_LEFT,
        S_BELL,
        S_ENT_CR,
        S_ENT_LF,
        S_ENT_LINE,
        S_ENT_NL,
        S_RIGHT
    } t_state;

endpackage

// ----- rtl/terminal_line_editor.sv -----
// ----------------------------------------------------------------------------
// terminal_line_editor
// VT100-style line editor: classify received bytes, edit one line, echo.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  rx      | in        | i_valid / o_stall  | t_in  (rx_byte, chunk_end)
//  tx      | out       | o_valid / i_stall  | t_out (out_byte, out_kind, run_last)
//
//  Bytes that cause no command are never stalled. An edit works through the
//  line tail byte by byte (shift, read back and echo, step the cursor back),
//  paced by the shift and echo sequencer and its registered-read line store
//  and by any output stalls.
//  Reset clears cursor, length and escape phase; the store needs no clearing.
//  A two-entry command queue lets the classifier run ahead of the sequencer.
// ----------------------------------------------------------------------------
module terminal_line_editor import tle_pkg::*; #(
    parameter int LINE_DEPTH = 31
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);
    logic f_valid, f_stall, q_valid, q_stall;
    t_cmd f_cmd, q_cmd;

    // classify and track escape sequences
    tle_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data,
        .o_cmd_valid(f_valid), .i_cmd_stall(f_stall), .o_cmd(f_cmd)
    );

    // hold pending commands
    tle_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(f_valid), .o_stall(f_stall), .i_cmd(f_cmd),
        .o_valid(q_valid), .i_stall(q_stall), .o_cmd(q_cmd)
    );

    // execute edits and echo
    tle_back #(.LINE_DEPTH(LINE_DEPTH)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .o_stall(q_stall), .i_cmd(q_cmd),
        .o_valid, .i_stall, .o_data
    );
endmodule

// ----- rtl/tle_front.sv -----
// ----------------------------------------------------------------------------
// tle_front
// Classify received bytes and track escape sequences; issue edit commands.
// ----------------------------------------------------------------------------
module tle_front import tle_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_cmd_valid,
    input  logic i_cmd_stall,
    output t_cmd o_cmd
);
    logic [1:0] r_phase, n_phase;
    logic       cmd_ok;
    logic [7:0] b;
    logic       acc;

    assign b = i_data.rx_byte;

    always_comb begin
        n_phase = r_phase;
        cmd_ok  = 1'b0;
        o_cmd.ch = b;
        o_cmd.op = OP_BELL;
        case (r_phase)
            2'd0: begin
                if (b >= C_SPACE && b < C_DEL) begin
                    cmd_ok = 1'b1; o_cmd.op = OP_INSERT;
                end else if (b == C_BS || b == C_DEL) begin
                    cmd_ok = 1'b1; o_cmd.op = OP_DELETE;
                end else if (b == C_TAB) begin
                    cmd_ok = 1'b1;
                end else if (b == C_CR) begin
                    cmd_ok = 1'b1; o_cmd.op = OP_ENTER;
                end else if (b == C_ESC) begin
                    if (i_data.chunk_end) cmd_ok = 1'b1;
                    else n_phase = 2'd1;
                end
            end
            2'd1: n_phase = (b == C_LBRK) ? 2'd2 : 2'd3;
            2'd2: begin
                n_phase = 2'd3;
                if (b == C_KEY_A || b == C_KEY_B) cmd_ok = 1'b1;
                else if (b == C_KEY_C) begin
                    cmd_ok = 1'b1; o_cmd.op = OP_RIGHT;
                end else if (b == C_KEY_D) begin
                    cmd_ok = 1'b1; o_cmd.op = OP_LEFT;
                end
            end
            default: ;
        endcase
        if (i_data.chunk_end) n_phase = 2'd0;
    end

    // stall only when a command is due and the queue cannot take it
    assign o_stall     = cmd_ok & i_cmd_stall;
    assign acc         = i_valid & ~o_stall;
    assign o_cmd_valid = i_valid & cmd_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_phase <= 2'd0;
        else if (acc) r_phase <= n_phase;
    end
endmodule

// ----- rtl/tle_queue.sv -----
// ----------------------------------------------------------------------------
// tle_queue
// Two-entry command queue between classifier and executor.
// ----------------------------------------------------------------------------
module tle_queue import tle_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_cmd i_cmd,
    output logic o_valid,
    input  logic i_stall,
    output t_cmd o_cmd
);
    t_cmd r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic wr, rd;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign wr = i_valid & ~o_stall;
    assign rd = o_valid & ~i_stall;

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end
endmodule

// ----- rtl/tle_back.sv -----
// ----------------------------------------------------------------------------
// tle_back
// Execute edit commands on the line store and emit echo and line bytes.
// ----------------------------------------------------------------------------
module tle_back import tle_pkg::*; #(
    parameter int LINE_DEPTH = 31
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_cmd i_cmd,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);
    localparam int PW = $clog2(LINE_DEPTH + 1);
    localparam int AW = $clog2(LINE_DEPTH);
    localparam logic [PW-1:0] CAP = PW'(LINE_DEPTH);

    logic [7:0] r_mem [LINE_DEPTH];
    t_state r_st, n_st;
    logic [PW-1:0] r_len, n_len, r_cur, n_cur, r_i, n_i, r_n, n_n;
    logic [7:0] r_ch, n_ch, r_rd;
    logic [1:0] r_sub, n_sub;
    logic r_ov, n_ov;
    t_out r_out, n_out;
    logic we;
    logic [AW-1:0] wa, ra;
    logic [7:0] wd;
    logic fire;

    // the output register is free when empty or being taken
    assign fire    = ~r_ov | ~i_stall;
    assign o_valid = r_ov;
    assign o_data  = r_out;
    assign o_stall = (r_st != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= wd;
        r_rd <= r_mem[ra];
    end

    always_comb begin
        n_st = r_st; n_len = r_len; n_cur = r_cur; n_i = r_i; n_n = r_n;
        n_ch = r_ch; n_sub = r_sub; n_ov = r_ov & i_stall; n_out = r_out;
        we = 1'b0; wa = r_i[AW-1:0]; wd = r_rd; ra = r_i[AW-1:0];
        case (r_st)
            S_IDLE: if (i_valid) begin
                n_ch = i_cmd.ch;
                case (i_cmd.op)
                    OP_INSERT: if (r_len < CAP) begin
                        n_n = r_len - r_cur; n_i = r_len; n_sub = 2'd0;
                        n_st = S_INS_SHIFT;
                    end
                    OP_DELETE: n_st = (r_cur == '0) ? S_BELL : S_DEL_BS;
                    OP_ENTER:  n_st = S_ENT_CR;
                    OP_RIGHT: if (r_cur >= r_len) n_st = S_BELL;
                              else begin n_st = S_RIGHT; n_sub = 2'd0; end
                    OP_LEFT: if (r_cur == '0) n_st = S_BELL;
                             else begin n_cur = r_cur - 1'b1;
                                 n_ch = C_BS; n_st = S_BELL; end
                    default: n_st = S_BELL;
                endcase
                if (i_cmd.op != OP_LEFT) n_ch = (i_cmd.op == OP_INSERT) ? i_cmd.ch : C_BELL;
                if (i_cmd.op == OP_LEFT && r_cur == '0) n_ch = C_BELL;
            end
            // move tail up one slot, from the end down to the cursor
            S_INS_SHIFT: begin
                if (r_i == r_cur) begin
                    we = 1'b1; wa = r_cur[AW-1:0]; wd = r_ch;
                    n_i = r_cur; n_sub = 2'd0; n_st = S_INS_ECHO;
                end else if (r_sub == 2'd0) begin
                    ra = AW'(r_i - 1'b1); n_sub = 2'd1;
                end else begin
                    we = 1'b1; n_i = r_i - 1'b1; n_sub = 2'd0;
                end
            end
            S_INS_ECHO: begin
                if (r_sub == 2'd0) begin
                    n_sub = 2'd1;
                end else if (fire) begin
                    n_ov = 1'b1; n_out = '{r_rd, 1'b0, 1'b0};
                    if (r_i == r_len) begin
                        n_len = r_len + 1'b1; n_cur = r_cur + 1'b1;
                        if (r_n == '0) begin
                            n_out.run_last = 1'b1; n_st = S_IDLE;
                        end else n_st = S_INS_LEFT;
                    end else begin
                        n_i = r_i + 1'b1; n_sub = 2'd0;
                    end
                end
            end
            S_INS_LEFT, S_DEL_LEFT: if (fire) begin
                n_ov = 1'b1; n_out = '{C_BS, 1'b0, 1'b0};
                n_n = r_n - 1'b1;
                if (r_n == PW'(1)) begin n_out.run_last = 1'b1; n_st = S_IDLE; end
            end
            S_DEL_BS: if (fire) begin
                n_ov = 1'b1; n_out = '{C_BS, 1'b0, 1'b0};
                n_i = r_cur; n_n = r_len - r_cur + 1'b1; n_sub = 2'd0;
                n_st = S_DEL_SHIFT;
            end
            S_DEL_SHIFT: begin
                if (r_i == r_len) n_st = S_DEL_SPACE;
                else if (r_sub == 2'd0) n_sub = 2'd1;
                else if (r_sub == 2'd1) begin
                    we = 1'b1; wa = AW'(r_i - 1'b1); n_sub = 2'd2;
                end else if (fire) begin
                    n_ov = 1'b1; n_out = '{r_rd, 1'b0, 1'b0};
                    n_i = r_i + 1'b1; n_sub = 2'd0;
                end
            end
            S_DEL_SPACE: if (fire) begin
                n_ov = 1'b1; n_out = '{C_SPACE, 1'b0, 1'b0};
                n_len = r_len - 1'b1; n_cur = r_cur - 1'b1; n_st = S_DEL_LEFT;
            end
            S_BELL: if (fire) begin
                n_ov = 1'b1; n_out = '{r_ch, 1'b0, 1'b1}; n_st = S_IDLE;
            end
            S_RIGHT: if (fire) begin
                n_ov = 1'b1;
                n_out = '{(r_sub == 2'd0) ? C_ESC : (r_sub == 2'd1) ? C_LBRK : C_KEY_C,
                          1'b0, r_sub == 2'd2};
                n_sub = r_sub + 1'b1;
                if (r_sub == 2'd2) begin n_cur = r_cur + 1'b1; n_st = S_IDLE; end
            end
            S_ENT_CR: if (fire) begin
                n_ov = 1'b1; n_out = '{C_CR, 1'b0, 1'b0}; n_st = S_ENT_LF;
            end
            S_ENT_LF: if (fire) begin
                n_ov = 1'b1; n_out = '{C_LF, 1'b0, 1'b0};
                n_i = '0; n_sub = 2'd0; n_st = S_ENT_LINE;
            end
            S_ENT_LINE: begin
                if (r_i == r_len) n_st = S_ENT_NL;
                else if (r_sub == 2'd0) n_sub = 2'd1;
                else if (fire) begin
                    n_ov = 1'b1; n_out = '{r_rd, 1'b1, 1'b0};
                    n_i = r_i + 1'b1; n_sub = 2'd0;
                end
            end
            S_ENT_NL: if (fire) begin
                n_ov = 1'b1; n_out = '{C_LF, 1'b1, 1'b1};
                n_len = '0; n_cur = '0; n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_len <= '0; r_cur <= '0; r_ov <= 1'b0; r_sub <= 2'd0;
        end else begin
            r_st <= n_st; r_len <= n_len; r_cur <= n_cur; r_ov <= n_ov; r_sub <= n_sub;
        end
        r_i <= n_i; r_n <= n_n; r_ch <= n_ch; r_out <= n_out;
    end
endmodule
